### rtl/core/hashed_timer_wheel_core_assert.svh
// Assertion macros for the timer wheel RTL.
`ifndef HASHED_TIMER_WHEEL_CORE_ASSERT_SVH
`define HASHED_TIMER_WHEEL_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define HTW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer wheel assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define HTW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer wheel assertion failed");

`endif

### rtl/core/htw_pkg.sv
// Shared constants and command codes for the hashed timer wheel.
package htw_pkg;

  localparam int TIMERS_DEF     = 16;
  localparam int WHEEL_SIZE_DEF = 64;

  localparam int MODE_W  = 2;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 16;

  localparam logic [MODE_W-1:0] MODE_ARM    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

endpackage

### rtl/core/htw_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module htw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/htw_div.sv
// Divider by a constant: reciprocal multiply, then quotient, then remainder, each in its own registered stage.
module htw_div #(
  parameter int DIVISOR = 64,
  parameter int NUM_W   = 16,
  parameter int REM_W   = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [REM_W-1:0] remainder
);

  localparam int     SHIFT = NUM_W + $clog2(DIVISOR);
  localparam int     MAG_W = NUM_W + 2;
  localparam int     PRD_W = NUM_W + MAG_W;
  localparam int     DIV_W = $clog2(DIVISOR + 1);
  localparam int     BCK_W = NUM_W + DIV_W;
  // ceil(2^SHIFT / DIVISOR), exact for every NUM_W-bit dividend
  localparam longint MAGIC = ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) /
                             longint'(DIVISOR);

  logic [3:0]       stage;
  logic [NUM_W-1:0] num;
  logic [PRD_W-1:0] prod;
  logic [NUM_W-1:0] quo;
  logic [BCK_W-1:0] back;
  logic [REM_W-1:0] rem;

  assign back      = BCK_W'(quo) * BCK_W'(DIVISOR);
  assign done      = stage[3];
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (stage[0]) begin
      prod <= PRD_W'(num) * PRD_W'(MAGIC);
    end
    if (stage[1]) begin
      quo <= NUM_W'(prod >> SHIFT);
    end
    if (stage[2]) begin
      rem <= REM_W'(num - NUM_W'(back));
    end
  end

endmodule

### rtl/core/hashed_timer_wheel_core.sv
// Hashed timer wheel top level: command sequencer, timer table and fire output.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+--------------------------------
//  cmd     | cmd_valid  | cmd_stall  | mode, timer_id, delay_ticks
//  fire    | fire_valid | fire_stall | fired_id, last
//
// Cancel clears the valid bit without leaving ST_IDLE. Arm waits in ST_DIV for
// the constant divider that splits the delay into bucket offset and rounds
// over three registered stages, then writes the entry. Tick scans the table
// (one RAM read per entry) and then walks the fired mask when anything fires.
// Reset clears the valid bits and the bucket pointer.
// fire_stall pauses the fired-id walk; cmd_stall stays high until it ends.
`include "hashed_timer_wheel_core_assert.svh"

module hashed_timer_wheel_core import htw_pkg::*; #(
  parameter int TIMERS     = TIMERS_DEF,
  parameter int WHEEL_SIZE = WHEEL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [ID_W-1:0]    timer_id,
  input  logic [DELAY_W-1:0] delay_ticks,
  output logic               fire_valid,
  input  logic               fire_stall,
  output logic [ID_W-1:0]    fired_id,
  output logic               last
);

  localparam int IW = $clog2(TIMERS);
  localparam int CW = $clog2(TIMERS + 1);
  localparam int BW = $clog2(WHEEL_SIZE);
  localparam int RW = $clog2(((2 ** DELAY_W) - 1) / WHEEL_SIZE + 1);
  localparam int EW = BW + RW;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t              state;
  logic [TIMERS-1:0]   entry_valid;
  logic [TIMERS-1:0]   fire_mask;
  logic [TIMERS-1:0]   mask_rest;
  logic [BW-1:0]       current_bucket;
  logic [IW-1:0]       arm_id;
  logic [CW-1:0]       rd_cnt;
  logic [IW-1:0]       idx;
  logic                ev_valid;
  logic [IW-1:0]       ev_idx;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;
  logic [BW-1:0]       rd_bucket;
  logic [RW-1:0]       rd_rounds;

  logic                div_start;
  logic                div_done;
  logic [DELAY_W-1:0]  div_quo;
  logic [BW-1:0]       div_rem;
  logic [BW:0]         bucket_sum;
  logic [BW-1:0]       bucket_new;

  logic                cmd_fire;
  logic                id_ok;
  logic                hit;
  logic                fire_free;
  logic                scan_end;

  assign cmd_stall  = (state != ST_IDLE);
  assign cmd_fire   = cmd_valid && !cmd_stall;
  assign id_ok      = 32'(timer_id) < 32'(TIMERS);
  assign div_start  = cmd_fire && (mode == MODE_ARM) && id_ok;
  assign idx        = rd_cnt[IW-1:0];
  assign fire_free  = !fire_valid || !fire_stall;
  assign mask_rest  = fire_mask & ~({{(TIMERS-1){1'b0}}, 1'b1} << idx);
  assign scan_end   = (rd_cnt == CW'(TIMERS)) && !ev_valid;

  assign {rd_bucket, rd_rounds} = ram_rdata;
  assign hit = ev_valid && entry_valid[ev_idx] && (rd_bucket == current_bucket);

  assign bucket_sum = {1'b0, current_bucket} + {1'b0, div_rem};
  assign bucket_new = (bucket_sum >= (BW+1)'(WHEEL_SIZE)) ?
                      BW'(bucket_sum - (BW+1)'(WHEEL_SIZE)) : BW'(bucket_sum);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = arm_id;
    ram_wdata = {bucket_new, RW'(div_quo)};
    if (state == ST_WRITE) begin
      ram_we = 1'b1;
    end else if ((state == ST_SCAN) && hit && (rd_rounds != '0)) begin
      ram_we    = 1'b1;
      ram_waddr = ev_idx;
      ram_wdata = {rd_bucket, rd_rounds - 1'b1};
    end
  end

  htw_ram #(
    .WIDTH (EW),
    .DEPTH (TIMERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  htw_div #(
    .DIVISOR (WHEEL_SIZE),
    .NUM_W   (DELAY_W),
    .REM_W   (BW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (delay_ticks),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entry_valid    <= '0;
      fire_mask      <= '0;
      current_bucket <= '0;
      rd_cnt         <= '0;
      ev_valid       <= 1'b0;
      fire_valid     <= 1'b0;
    end else begin
      if (fire_valid && !fire_stall && !((state == ST_EMIT) && fire_mask[idx])) begin
        fire_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            unique case (mode)
              MODE_ARM: begin
                if (id_ok) begin
                  state <= ST_DIV;
                end
              end
              MODE_CANCEL: begin
                if (id_ok) begin
                  entry_valid[IW'(timer_id)] <= 1'b0;
                end
              end
              MODE_TICK: begin
                rd_cnt   <= '0;
                ev_valid <= 1'b0;
                state    <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          entry_valid[arm_id] <= 1'b1;
          state               <= ST_IDLE;
        end
        ST_SCAN: begin
          if (rd_cnt < CW'(TIMERS)) begin
            rd_cnt   <= rd_cnt + 1'b1;
            ev_valid <= 1'b1;
          end else begin
            ev_valid <= 1'b0;
          end
          if (hit && (rd_rounds == '0)) begin
            entry_valid[ev_idx] <= 1'b0;
            fire_mask[ev_idx]   <= 1'b1;
          end
          if (scan_end) begin
            current_bucket <= (current_bucket == BW'(WHEEL_SIZE - 1)) ?
                              '0 : current_bucket + 1'b1;
            rd_cnt <= '0;
            state  <= (fire_mask != '0) ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (fire_mask[idx]) begin
            if (fire_free) begin
              fire_mask[idx] <= 1'b0;
              fire_valid     <= 1'b1;
              if (mask_rest == '0) begin
                state <= ST_IDLE;
              end else begin
                rd_cnt <= rd_cnt + 1'b1;
              end
            end
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= idx;
    if (div_start) begin
      arm_id <= IW'(timer_id);
    end
    if ((state == ST_EMIT) && fire_mask[idx] && fire_free) begin
      fired_id <= ID_W'(idx);
      last     <= (mask_rest == '0);
    end
  end

  `HTW_ASSERT_NXT(a_mask_only_drains, state == ST_EMIT, (fire_mask & ~$past(fire_mask)) == '0)
  `HTW_ASSERT_IMP(a_fired_is_freed, (state == ST_EMIT) && fire_mask[idx], !entry_valid[idx])
  `HTW_ASSERT_NXT(a_bucket_moves_on_scan, state != ST_SCAN, $stable(current_bucket))

endmodule

### tb/sv/hashed_timer_wheel_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the hashed timer wheel core: directed and random arm/cancel/tick/no-op traffic.
module hashed_timer_wheel_core_tb;
  import htw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT = 27;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } fire_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [MODE_W-1:0]  mode = MODE_ARM;
  logic [ID_W-1:0]    timer_id = '0;
  logic [DELAY_W-1:0] delay_ticks = '0;
  logic               fire_valid;
  logic               fire_stall = 1'b0;
  logic [ID_W-1:0]    fired_id;
  logic               last;

  hashed_timer_wheel_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .mode        (mode),
    .timer_id    (timer_id),
    .delay_ticks (delay_ticks),
    .fire_valid  (fire_valid),
    .fire_stall  (fire_stall),
    .fired_id    (fired_id),
    .last        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow timer table
  logic                tmr_live [TIMERS_DEF];
  logic [5:0]          tmr_slot [TIMERS_DEF];
  logic [9:0]          tmr_laps [TIMERS_DEF];
  logic [5:0]          wheel_pos;

  cmd_t  cmd_backlog[$];
  fire_t due_fires[$];
  int    fires_predicted = 0;
  int    errs = 0;
  int    cycles = 0;
  logic  calm = 1'b0;
  logic  rx_hold_go = 1'b0;

  task automatic wheel_step(input cmd_t c);
    logic [ID_W-1:0] hits[$];
    fire_t f;
    case (c.mode)
      MODE_ARM: begin
        tmr_live[c.id] = 1'b1;
        tmr_slot[c.id] = 6'((int'(wheel_pos) + int'(c.delay)) % WHEEL_SIZE_DEF);
        tmr_laps[c.id] = 10'(int'(c.delay) / WHEEL_SIZE_DEF);
      end
      MODE_CANCEL: tmr_live[c.id] = 1'b0;
      MODE_TICK: begin
        for (int i = 0; i < TIMERS_DEF; i++) begin
          if (tmr_live[i] && tmr_slot[i] == wheel_pos) begin
            if (tmr_laps[i] > 0) begin
              tmr_laps[i] = tmr_laps[i] - 10'd1;
            end else begin
              tmr_live[i] = 1'b0;
              hits.push_back(ID_W'(i));
            end
          end
        end
        for (int k = 0; k < hits.size(); k++) begin
          f.id = hits[k];
          f.last = (k == hits.size() - 1);
          due_fires.push_back(f);
          fires_predicted++;
        end
        wheel_pos = 6'((int'(wheel_pos) + 1) % WHEEL_SIZE_DEF);
      end
      default: ;
    endcase
  endtask

  task automatic send(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                      input logic [DELAY_W-1:0] d);
    cmd_t c;
    c.mode = m;
    c.id = id;
    c.delay = d;
    cmd_backlog.push_back(c);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    int p;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, 99);
    if (r < 30) c.mode = MODE_ARM;
    else if (r < 40) c.mode = MODE_CANCEL;
    else if (r < 45) c.mode = MODE_NOP;
    else c.mode = MODE_TICK;
    c.id = ID_W'($urandom_range(0, 15));
    if (p < 70) c.delay = DELAY_W'($urandom_range(0, 20));
    else if (p < 85) c.delay = DELAY_W'($urandom_range(0, 200));
    else c.delay = DELAY_W'($urandom);
    return c;
  endfunction

  // sampled on the falling edge so the rising-edge updates have settled
  task automatic wait_drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || due_fires.size() != 0);
  endtask

  // command driver
  always @(posedge clk) begin : drv
    cmd_t seen;
    cmd_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        seen.mode = mode;
        seen.id = timer_id;
        seen.delay = delay_ticks;
        wheel_step(seen);
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
          mode <= nxt.mode;
          timer_id <= nxt.id;
          delay_ticks <= nxt.delay;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // fire monitor and receiver stall
  always @(posedge clk) begin : mon
    fire_t want;
    int hold_left;
    logic hold_used;
    if (rst) begin
      fire_stall <= 1'b0;
      hold_left = 0;
      hold_used = 1'b0;
    end else begin
      if (fire_valid && !fire_stall) begin
        if (due_fires.size() == 0) begin
          $error("unexpected fire item: fired_id %0d last %0b", fired_id, last);
          errs++;
        end else begin
          want = due_fires.pop_front();
          if (fired_id !== want.id) begin
            $error("fired_id: expected %0d, actual %0d", want.id, fired_id);
            errs++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            errs++;
          end
        end
      end
      if (rx_hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        fire_stall <= 1'b1;
      end else begin
        fire_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("hashed_timer_wheel_core_tb: FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < TIMERS_DEF; i++) begin
      tmr_live[i] = 1'b0;
      tmr_slot[i] = '0;
      tmr_laps[i] = '0;
    end
    wheel_pos = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero delay, max delay, full-lap delay, re-arm, idle cancel, mode three
    send(MODE_ARM, 4'd0, 16'd0);
    send(MODE_TICK, 4'd7, 16'hFFFF);
    send(MODE_ARM, 4'd15, 16'hFFFF);
    send(MODE_ARM, 4'd3, 16'd64);
    send(MODE_ARM, 4'd5, 16'd1);
    send(MODE_ARM, 4'd5, 16'd2);
    send(MODE_CANCEL, 4'd9, 16'h1234);
    send(MODE_NOP, 4'd4, 16'h5A5A);
    send(MODE_ARM, 4'd1, 16'd1);
    send(MODE_ARM, 4'd2, 16'd1);
    send(MODE_ARM, 4'd6, 16'd2);
    send(MODE_TICK, 4'd0, 16'd0);
    send(MODE_TICK, 4'd0, 16'd0);
    send(MODE_TICK, 4'd0, 16'd0);
    send(MODE_CANCEL, 4'd15, 16'd0);
    send(MODE_ARM, 4'd8, 16'd0);
    send(MODE_CANCEL, 4'd8, 16'd0);
    send(MODE_TICK, 4'd0, 16'd0);
    send(MODE_ARM, 4'd14, 16'd128);
    send(MODE_ARM, 4'd12, 16'd63);
    send(MODE_TICK, 4'd0, 16'd0);
    wait_drain();

    repeat (40) cmd_backlog.push_back(rand_cmd());

    calm = 1'b1;
    repeat (30) cmd_backlog.push_back(rand_cmd());
    wait_drain();
    calm = 1'b0;

    // every timer in one bucket, receiver holding off
    for (int i = 0; i < TIMERS_DEF; i++) send(MODE_ARM, ID_W'(i), 16'd0);
    rx_hold_go = 1'b1;
    send(MODE_TICK, 4'd0, 16'd0);
    for (int i = 0; i < 6; i++) send(MODE_ARM, ID_W'(i), DELAY_W'(i % 3));
    repeat (4) send(MODE_TICK, 4'd0, 16'd0);
    wait_drain();

    repeat (30) cmd_backlog.push_back(rand_cmd());
    wait_drain();

    while (fires_predicted < 60) begin
      repeat (5) begin
        send(MODE_ARM, ID_W'($urandom_range(0, 15)), DELAY_W'($urandom_range(0, 3)));
        send(MODE_TICK, ID_W'($urandom_range(0, 15)), DELAY_W'($urandom));
      end
      wait_drain();
    end

    repeat (100) @(posedge clk);
    if (due_fires.size() != 0) begin
      $error("%0d fire items never arrived", due_fires.size());
      errs++;
    end
    if (errs == 0) begin
      $display("hashed_timer_wheel_core_tb: PASS");
    end else begin
      $display("hashed_timer_wheel_core_tb: FAIL");
    end
    $finish;
  end
endmodule
